// ----- design/mexp_pkg.sv -----
// Package for the modular exponentiation block: sequencer states and fixed constants.
// No dependencies. Imported by the top level, the checker and tb_top.
`default_nettype none

package mexp_pkg;

   // width of the base field, fixed by the item format
   localparam int BASE_BITS = 63;
   // counter width for the longest step sweep (base reduction)
   localparam int CNT_W = $clog2(BASE_BITS);
   // modulus after reset (1e9 + 7)
   localparam logic [63:0] MOD_RESET = 64'd1000000007;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_CHECK,
      ST_MUL_ACC,
      ST_MUL_SQ,
      ST_DONE
   } mexp_state_type;

endpackage

`default_nettype wire

// ----- design/mexp_modstep.sv -----
// One step of the shared shift-add modular unit: (2*r + addend) mod m.
// Requires r < m and addend < m. No package dependencies.
`default_nettype none

module mexp_modstep #(
   parameter int WIDTH = 31
) (
   input  wire  logic [WIDTH-1:0] r,
   input  wire  logic [WIDTH-1:0] addend,
   input  wire  logic [WIDTH-1:0] m,
   output logic       [WIDTH-1:0] r_next
);

   logic [WIDTH:0] dbl;
   logic [WIDTH:0] dbl_sub;
   logic [WIDTH-1:0] dbl_red;
   logic [WIDTH:0] sum;
   logic [WIDTH:0] sum_sub;

   always_comb begin
      dbl     = {r, 1'b0};
      dbl_sub = dbl - {1'b0, m};
      dbl_red = (dbl >= {1'b0, m}) ? dbl_sub[WIDTH-1:0] : dbl[WIDTH-1:0];
      sum     = {1'b0, dbl_red} + {1'b0, addend};
      sum_sub = sum - {1'b0, m};
      r_next  = (sum >= {1'b0, m}) ? sum_sub[WIDTH-1:0] : sum[WIDTH-1:0];
   end

endmodule

`default_nettype wire

// ----- design/modular_exponentiation.sv -----
// Top level of the modular exponentiation block: sequencer, operand registers, output register.
// Depends on mexp_pkg and mexp_modstep.
//
// Computes base^exponent mod modulus (opcode 0) or base^(modulus-2) mod modulus (opcode 1,
// the Fermat inverse for a prime modulus) by right-to-left square-and-multiply. One word is
// taken at a time; req_stall stays high until its result has been loaded into the output
// register, which may still hold the previous result while the next word is accepted. All
// arithmetic runs through one shift-add modular step unit, one bit per cycle: the base is
// first reduced, then each exponent bit is inspected and costs a square, plus a multiply
// into the accumulator first when the bit is set. The walk stops at the highest set exponent
// bit. A modulus below 2 gives 0. The modulus is written through csr_wr_en and csr_wr_data;
// it is to be written only while the block is idle, which the block itself does not enforce;
// it resets to 1000000007.
`default_nettype none

module modular_exponentiation
   import mexp_pkg::*;
#(
   parameter int MOD_BITS = 31,
   parameter int EXP_BITS = 63
) (
   input  wire  logic                 clock,
   input  wire  logic                 reset,
   input  wire  logic                 csr_wr_en,
   input  wire  logic [MOD_BITS-1:0]  csr_wr_data,
   input  wire  logic                 req_valid,
   output logic                       req_stall,
   input  wire  logic                 req_opcode,
   input  wire  logic [BASE_BITS-1:0] req_base,
   input  wire  logic [EXP_BITS-1:0]  req_exponent,
   output logic                       rsp_valid,
   input  wire  logic                 rsp_stall,
   output logic [MOD_BITS-1:0]        rsp_power_result
);

   mexp_state_type state_ff, state_in;

   logic [MOD_BITS-1:0]  modulus_ff, modulus_in;
   logic [BASE_BITS-1:0] base_sh_ff, base_sh_in;
   logic [EXP_BITS-1:0]  exp_ff, exp_in;
   logic [MOD_BITS-1:0]  acc_ff, acc_in;
   logic [MOD_BITS-1:0]  sq_ff, sq_in;
   logic [MOD_BITS-1:0]  r_ff, r_in;
   logic [MOD_BITS-1:0]  mplr_ff, mplr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [MOD_BITS-1:0]  result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [MOD_BITS-1:0]  rsp_data_ff, rsp_data_in;

   logic                 req_take;
   logic                 rsp_free;
   logic                 mod_small;
   logic [MOD_BITS-1:0]  mod_minus2;
   logic [MOD_BITS-1:0]  step_addend;
   logic [MOD_BITS-1:0]  step_out;
   logic                 cnt_last;

   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MOD_BITS - 1);
   localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(BASE_BITS - 1);
   localparam logic [MOD_BITS-1:0] ONE = MOD_BITS'(1);

   assign req_stall        = (state_ff != ST_IDLE);
   assign req_take         = req_valid && !req_stall;
   assign rsp_free         = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;
   assign mod_small        = (modulus_ff < MOD_BITS'(2));
   assign mod_minus2       = modulus_ff - MOD_BITS'(2);
   assign cnt_last         = (cnt_ff == '0);

   // addend: one base bit while reducing, else the multiplicand when the multiplier bit is set
   always_comb begin
      case (state_ff)
         ST_REDUCE:  step_addend = {{(MOD_BITS-1){1'b0}}, base_sh_ff[BASE_BITS-1]};
         ST_MUL_ACC: step_addend = mplr_ff[MOD_BITS-1] ? acc_ff : '0;
         ST_MUL_SQ:  step_addend = mplr_ff[MOD_BITS-1] ? sq_ff : '0;
         default:    step_addend = '0;
      endcase
   end

   mexp_modstep #(
      .WIDTH(MOD_BITS)
   ) u_step (
      .r      (r_ff),
      .addend (step_addend),
      .m      (modulus_ff),
      .r_next (step_out)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = mod_small ? ST_DONE : ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (cnt_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MUL_ACC;
            end else begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_ACC: begin
            if (cnt_last) begin
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_SQ: begin
            if (cnt_last) begin
               state_in = ST_CHECK;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      modulus_in   = csr_wr_en ? csr_wr_data : modulus_ff;
      base_sh_in   = base_sh_ff;
      exp_in       = exp_ff;
      acc_in       = acc_ff;
      sq_in        = sq_ff;
      r_in         = r_ff;
      mplr_in      = mplr_ff;
      cnt_in       = cnt_ff;
      result_in    = result_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               base_sh_in = req_base;
               exp_in     = req_opcode ? EXP_BITS'(mod_minus2) : req_exponent;
               r_in       = '0;
               cnt_in     = RED_LAST;
               result_in  = '0;
            end
         end
         ST_REDUCE: begin
            r_in       = step_out;
            base_sh_in = base_sh_ff << 1;
            cnt_in     = cnt_ff - CNT_W'(1);
            if (cnt_last) begin
               sq_in  = step_out;
               acc_in = ONE;
            end
         end
         ST_CHECK: begin
            r_in    = '0;
            mplr_in = sq_ff;
            cnt_in  = MUL_LAST;
            if (exp_ff == '0) begin
               result_in = acc_ff;
            end
         end
         ST_MUL_ACC: begin
            r_in    = step_out;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_last) begin
               // hand over to the square of the same bit
               acc_in  = step_out;
               r_in    = '0;
               mplr_in = sq_ff;
               cnt_in  = MUL_LAST;
            end
         end
         ST_MUL_SQ: begin
            r_in    = step_out;
            mplr_in = mplr_ff << 1;
            cnt_in  = cnt_ff - CNT_W'(1);
            if (cnt_last) begin
               sq_in  = step_out;
               exp_in = exp_ff >> 1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = result_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         modulus_ff   <= MOD_RESET[MOD_BITS-1:0];
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         modulus_ff   <= modulus_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      base_sh_ff  <= base_sh_in;
      exp_ff      <= exp_in;
      acc_ff      <= acc_in;
      sq_ff       <= sq_in;
      r_ff        <= r_in;
      mplr_ff     <= mplr_in;
      cnt_ff      <= cnt_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- dv/mexp_tb_pkg.sv -----
// Shared opcode codes for the modular exponentiation testbench.
// No dependencies. Imported by the checker and by tb_top.
package mexp_tb_pkg;

   typedef enum logic {
      OP_POWER   = 1'b0,
      OP_INVERSE = 1'b1
   } mexp_op_type;

endpackage

// ----- dv/mexp_checker.sv -----
// Checker for modular_exponentiation: follows the modulus register and both channels,
// predicts each power_result by square-and-multiply and compares in order.
// Depends on mexp_pkg (reset modulus, base width) and mexp_tb_pkg (opcodes).
module mexp_checker
   import mexp_pkg::*;
   import mexp_tb_pkg::*;
#(
   parameter int MOD_BITS = 31,
   parameter int EXP_BITS = 63
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [MOD_BITS-1:0]  csr_wr_data,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_opcode,
   input  logic [BASE_BITS-1:0] req_base,
   input  logic [EXP_BITS-1:0]  req_exponent,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [MOD_BITS-1:0]  rsp_power_result,
   output int                   mismatch_count,
   output int                   pending_words
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      int                  word_no;
      mexp_op_type         op;
      logic [MOD_BITS-1:0] power;
   } power_expect_type;

   power_expect_type    power_q[$];
   logic [MOD_BITS-1:0] modulus_copy;
   int                  words_in;

   initial begin
      mismatch_count = 0;
      pending_words  = 0;
      words_in       = 0;
      modulus_copy   = MOD_RESET[MOD_BITS-1:0];
   end

   function automatic logic [MOD_BITS-1:0] predict_power(mexp_op_type op,
                                                         logic [BASE_BITS-1:0] base,
                                                         logic [EXP_BITS-1:0] expo,
                                                         logic [MOD_BITS-1:0] m);
      logic [63:0]         acc;
      logic [63:0]         sq;
      logic [63:0]         mm;
      logic [EXP_BITS-1:0] e;
      if (m < 2)
         return '0;
      mm  = 64'(m);
      // inverse by Fermat: the exponent field is replaced by m - 2
      e   = (op == OP_INVERSE) ? EXP_BITS'(64'(m) - 64'd2) : expo;
      acc = 64'd1;
      sq  = 64'(base) % mm;
      for (int i = 0; i < EXP_BITS; i++) begin
         if (e[i])
            acc = (acc * sq) % mm;
         sq = (sq * sq) % mm;
      end
      return acc[MOD_BITS-1:0];
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      power_expect_type want;
      if (reset) begin
         modulus_copy = MOD_RESET[MOD_BITS-1:0];
      end else begin
         // retire a result word before taking the next request
         if (rsp_valid && !rsp_stall) begin
            if (power_q.size() == 0) begin
               report_mismatch($sformatf("result %0d with no word outstanding",
                                         rsp_power_result));
            end else begin
               want = power_q.pop_front();
               if (rsp_power_result !== want.power)
                  report_mismatch($sformatf("word %0d (%s): power_result %0d, want %0d",
                                            want.word_no, want.op.name(),
                                            rsp_power_result, want.power));
            end
         end
         if (req_valid && !req_stall) begin
            want.word_no = words_in;
            want.op      = mexp_op_type'(req_opcode);
            want.power   = predict_power(want.op, req_base, req_exponent, modulus_copy);
            power_q.insert(power_q.size(), want);
            words_in++;
         end
         if (csr_wr_en)
            modulus_copy = csr_wr_data;
      end
      pending_words = power_q.size();
   end

endmodule

// ----- dv/tb_top.sv -----
// Testbench top for modular_exponentiation: clock, reset, modulus writes and request words.
// Depends on mexp_pkg, mexp_tb_pkg, mexp_checker and the block itself.
module tb_top;
   import mexp_pkg::*;
   import mexp_tb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MOD_BITS      = 31;
   localparam int EXP_BITS      = 63;
   localparam int LIMIT_CYCLES  = 3_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 4200;
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_WORDS   = 17;
   localparam logic [62:0] ALL_ONES = {63{1'b1}};

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 csr_wr_en = 1'b0;
   logic [MOD_BITS-1:0]  csr_wr_data = '0;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = 1'b0;
   logic [BASE_BITS-1:0] req_base = '0;
   logic [EXP_BITS-1:0]  req_exponent = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [MOD_BITS-1:0]  rsp_power_result;

   int                   mismatch_count;
   int                   pending_words;
   int                   cycle_count = 0;
   int                   words_sent = 0;
   int                   inverse_sent = 0;
   int                   modulus_settings = 1;
   bit                   quiet = 1'b0;
   logic [MOD_BITS-1:0]  cur_modulus = MOD_RESET[MOD_BITS-1:0];

   modular_exponentiation #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) dut (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result)
   );

   mexp_checker #(.MOD_BITS(MOD_BITS), .EXP_BITS(EXP_BITS)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_base         (req_base),
      .req_exponent     (req_exponent),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_power_result (rsp_power_result),
      .mismatch_count   (mismatch_count),
      .pending_words    (pending_words)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  pending_words);
         $display("DONE: errors detected");
         $finish;
      end
   end

   // result side: stall with a chance of about 7 in a hundred, except in quiet phases
   always @(negedge clock)
      rsp_stall <= !quiet && ($urandom_range(99) < 7);

   // called just after a falling edge; returns just after the falling edge following acceptance
   task automatic send_word(mexp_op_type op, logic [BASE_BITS-1:0] base,
                            logic [EXP_BITS-1:0] expo);
      while (!quiet && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_base     <= base;
      req_exponent <= expo;
      do @(posedge clock); while (req_stall);
      words_sent++;
      if (op == OP_INVERSE)
         inverse_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every outstanding word has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_words != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_modulus(logic [MOD_BITS-1:0] value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_modulus  = value;
      modulus_settings++;
      @(negedge clock);
   endtask

   function automatic logic [MOD_BITS-1:0] random_modulus(int phase);
      case (phase)
         0:       return 31'd1000000007;
         1:       return 31'd998244353;
         2:       return 31'd65537;
         3:       return 31'd3;
         4:       return MOD_BITS'($urandom) | 31'h4000_0001;
         5:       return MOD_BITS'($urandom_range(32'h7FFF_FFFF, 2));
         default: return 31'h7FFF_FFFF;
      endcase
   endfunction

   function automatic logic [62:0] random_wide();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[62:0];
   endfunction

   function automatic logic [BASE_BITS-1:0] random_base();
      logic [31:0] k;
      k = $urandom;
      case ($urandom_range(3))
         0:       return random_wide();
         1:       return BASE_BITS'($urandom_range(15));
         2:       return 63'(cur_modulus) * 63'(k);   // multiple of the modulus
         default: return ALL_ONES - 63'($urandom_range(255));
      endcase
   endfunction

   // mostly bounded bit lengths so that run time stays sensible
   function automatic logic [EXP_BITS-1:0] random_exponent();
      int          len;
      logic [62:0] e;
      len = $urandom_range(EXP_BITS);
      if (len == 0)
         return '0;
      e = random_wide() & (ALL_ONES >> (EXP_BITS - len));
      e[len-1] = 1'b1;
      return e;
   endfunction

   initial begin
      mexp_op_type op;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset modulus, 1e9 + 7
      send_word(OP_POWER, 63'd0, 63'd0);
      send_word(OP_POWER, 63'd0, 63'd5);
      send_word(OP_POWER, ALL_ONES, ALL_ONES);
      send_word(OP_POWER, 63'd1, ALL_ONES);
      send_word(OP_INVERSE, 63'd2, 63'd0);
      send_word(OP_INVERSE, 63'd12345, ALL_ONES);
      send_word(OP_INVERSE, 63'd0, 63'd7);
      send_word(OP_INVERSE, 63'd2000000014, 63'd1);

      // smallest legal modulus: inverse exponent collapses to zero
      write_modulus(31'd2);
      send_word(OP_INVERSE, 63'd3, 63'd9);
      send_word(OP_POWER, 63'd4, 63'd3);
      send_word(OP_POWER, 63'd5, 63'd7);

      write_modulus(31'h7FFF_FFFF);
      send_word(OP_POWER, ALL_ONES, ALL_ONES);
      send_word(OP_INVERSE, ALL_ONES, 63'd0);
      send_word(OP_INVERSE, 63'h7FFF_FFFF, 63'd3);
      send_word(OP_POWER, 63'h7FFF_FFFE, 63'd2);

      // degenerate moduli give zero for every word
      write_modulus(31'd0);
      send_word(OP_POWER, 63'd7, 63'd3);
      send_word(OP_INVERSE, 63'd9, 63'd0);
      write_modulus(31'd1);
      send_word(OP_POWER, 63'd0, 63'd0);
      send_word(OP_INVERSE, 63'd5, 63'd1);

      // composite modulus with the inverse opcode
      write_modulus(31'd15);
      send_word(OP_INVERSE, 63'd4, 63'd0);

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         write_modulus(random_modulus(ph));
         quiet = (ph == 3 || ph == 4);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if ($urandom_range(19) == 0)
               drain_results();
            op = ($urandom_range(3) == 0) ? OP_INVERSE : OP_POWER;
            send_word(op, random_base(), random_exponent());
         end
      end
      quiet = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(negedge clock);

      $display("covered %0d words (%0d inverse) over %0d modulus settings,", words_sent,
               inverse_sent, modulus_settings);
      $display("including moduli 0, 1, 2, 15 and 2^31-1, in %0d cycles", cycle_count);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- modular_exponentiation.f -----
design/mexp_pkg.sv
design/mexp_modstep.sv
design/modular_exponentiation.sv
dv/mexp_tb_pkg.sv
dv/mexp_checker.sv
dv/tb_top.sv
